// File: rtl/vdt_pkg.sv
package vdt_pkg;

    // Field widths fixed by the stream formats
    localparam int COORD_W    = 32;
    localparam int AXES       = 3;
    localparam int ENTRY_W    = COORD_W * AXES;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int TOL_W      = 31;
    localparam int VIDX_W     = 10;
    localparam int VCNT_W     = 11;
    localparam int OUT_DATA_W = 24;

    // Per-entry compare result coming back from the compare unit
    typedef struct packed {
        logic valid;
        logic match;
    } cmp_res_t;

endpackage

// File: rtl/vdt_ram.sv
module vdt_ram #(
    parameter int WIDTH  = 96,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/vdt_cmp.sv
module vdt_cmp
    import vdt_pkg::*;
#(
    parameter int TAG_W = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ENTRY_W-1:0] key,
    input  logic [ENTRY_W-1:0] entry,
    input  logic [TOL_W-1:0]   tol,
    input  logic               in_valid,
    input  logic [TAG_W-1:0]   in_tag,
    input  logic               flush,
    output cmp_res_t           res,
    output logic [TAG_W-1:0]   res_tag
);

    logic [DIFF_W-1:0] diff_next [AXES];
    logic [DIFF_W-1:0] diff_reg  [AXES];
    logic [TAG_W-1:0]  tag_reg;
    logic              valid_reg;
    logic [AXES-1:0]   axis_ok;
    logic signed [DIFF_W-1:0] tol_pos;
    logic signed [DIFF_W-1:0] tol_neg;

    // Stage 1: exact signed difference per axis, one bit wider than a coordinate
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            diff_next[a] = {key[a*COORD_W + COORD_W-1], key[a*COORD_W +: COORD_W]}
                         - {entry[a*COORD_W + COORD_W-1], entry[a*COORD_W +: COORD_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            diff_reg[a] <= diff_next[a];
        end
        tag_reg <= in_tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid && !flush;
        end
    end

    // Stage 2: |d| <= tol  <=>  -tol <= d <= tol
    assign tol_pos = $signed({{(DIFF_W-TOL_W){1'b0}}, tol});
    assign tol_neg = -tol_pos;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            axis_ok[a] = ($signed(diff_reg[a]) <= tol_pos)
                      && ($signed(diff_reg[a]) >= tol_neg);
        end
    end

    assign res.valid = valid_reg;
    assign res.match = &axis_ok;
    assign res_tag   = tag_reg;

endmodule

// File: rtl/vertex_dedup_table_unit.sv
// Search: the set is scanned in storage order and stops at the first match; an
// empty set resolves without a compare. Throughput: one item per search; a new
// item is taken only in idle. The table is scanned one entry per cycle through a
// single RAM read port feeding a two-stage compare unit.
// Reset: asynchronous, active low; clears the entry count, the handshakes and
// sets the tolerance to 1. Table contents are not cleared.
module vertex_dedup_table_unit
    import vdt_pkg::*;
#(
    parameter int MAX_VERTS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration
    input  logic                  cfg_wr_en,
    input  logic [TOL_W-1:0]      cfg_wr_data,   // match_tolerance
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [ENTRY_W-1:0]    s_axis_tdata,  // coord_x, coord_y, coord_z
    input  logic                  s_axis_tlast,  // last_vertex
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // vertex_index, is_new, table_full,
                                                 // unique_count, zero pad
);

    localparam int AW = $clog2(MAX_VERTS);
    localparam int CW = $clog2(MAX_VERTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESOLVE
    } state_t;

    state_t               state_reg;
    logic [TOL_W-1:0]     tol_reg;
    logic [CW-1:0]        count_reg;
    logic [ENTRY_W-1:0]   key_reg;
    logic                 last_reg;
    logic [CW-1:0]        issue_ptr_reg;
    logic                 p1_valid_reg;
    logic [AW-1:0]        p1_tag_reg;
    logic                 hit_reg;
    logic [AW-1:0]        found_reg;
    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                 issue_done;
    logic                 rd_en;
    logic                 cmp_hit;
    logic                 out_free;
    logic                 room;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   rd_data;
    cmp_res_t             cmp_res;
    logic [AW-1:0]        cmp_tag;
    logic [AW-1:0]        res_idx;
    logic [CW-1:0]        res_count;
    logic                 res_new;
    logic                 res_full;

    // Table storage
    vdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VERTS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (key_reg),
        .re    (rd_en),
        .raddr (issue_ptr_reg[AW-1:0]),
        .rdata (rd_data)
    );

    // Shared tolerance compare
    vdt_cmp #(
        .TAG_W (AW)
    ) u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .key      (key_reg),
        .entry    (rd_data),
        .tol      (tol_reg),
        .in_valid (p1_valid_reg),
        .in_tag   (p1_tag_reg),
        .flush    (cmp_hit),
        .res      (cmp_res),
        .res_tag  (cmp_tag)
    );

    // Scan control
    assign issue_done = (issue_ptr_reg == count_reg);
    assign cmp_hit    = (state_reg == ST_SEARCH) && cmp_res.valid && cmp_res.match;
    assign rd_en      = (state_reg == ST_SEARCH) && !issue_done && !cmp_hit;

    // Resolve: match, append or overflow
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign room      = (count_reg < MAX_CNT);
    assign wr_en     = (state_reg == ST_RESOLVE) && out_free && !hit_reg && room;
    assign res_new   = !hit_reg && room;
    assign res_full  = !hit_reg && !room;
    assign res_idx   = hit_reg ? found_reg : (room ? count_reg[AW-1:0] : '0);
    assign res_count = res_new ? count_reg + CW'(1) : count_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_W'(1);
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            key_reg  <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        p1_tag_reg <= issue_ptr_reg[AW-1:0];
        if (cmp_hit)
        begin
            found_reg <= cmp_tag;
        end
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_ptr_reg <= '0;
            p1_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            p1_valid_reg <= rd_en;
            // resolve loads the next result in the same cycle as a drain
            if (out_valid_reg && m_axis_tready && (state_reg != ST_RESOLVE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        issue_ptr_reg <= '0;
                        hit_reg       <= 1'b0;
                        state_reg     <= ST_SEARCH;
                    end
                end

                ST_SEARCH:
                begin
                    if (rd_en)
                    begin
                        issue_ptr_reg <= issue_ptr_reg + CW'(1);
                    end
                    if (cmp_hit)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= ST_RESOLVE;
                    end
                    else if (issue_done && !p1_valid_reg && !cmp_res.valid)
                    begin
                        state_reg <= ST_RESOLVE;
                    end
                end

                ST_RESOLVE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {1'b0, VCNT_W'(res_count), res_full, res_new,
                                          VIDX_W'(res_idx)};
                        count_reg     <= last_reg ? '0 : res_count;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: bench/vertex_dedup_table_unit_tb.sv
module vertex_dedup_table_unit_tb;
    import vdt_pkg::*;

    localparam int MAX_VERTS = 1024;
    localparam int NUM_DIR   = 21;
    localparam int POOL_SZ   = 6;
    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 97;
    localparam int C_MIN     = 32'h8000_0000;
    localparam int C_MAX     = 32'h7FFF_FFFF;
    localparam logic [TOL_W-1:0] TOL_MAX = '1;

    // Result fields, lowest bit last, same layout as the result tdata
    typedef struct packed {
        logic [VCNT_W-1:0] unique_count;
        logic              table_full;
        logic              is_new;
        logic [VIDX_W-1:0] vertex_index;
    } weld_result_t;

    // One directed row: optional tolerance write, the vertex, optional typed result
    typedef struct packed {
        bit              set_tol;
        bit [TOL_W-1:0]  tol;
        int              x;
        int              y;
        int              z;
        bit              last;
        bit              typed;
        bit [VIDX_W-1:0] e_idx;
        bit              e_new;
        bit              e_full;
        bit [VCNT_W-1:0] e_cnt;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [TOL_W-1:0]      cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [ENTRY_W-1:0]    s_axis_tdata = '0;   // coord_x, coord_y, coord_z
    logic                  s_axis_tlast = 1'b0; // last_vertex
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // vertex_index, is_new, table_full,
                                                // unique_count, zero pad

    // Predictor state: welded vertices of the current set and the tolerance
    int             uniq_tbl [MAX_VERTS][3];
    int unsigned    weld_count = 0;
    bit [TOL_W-1:0] weld_tol = 1;

    weld_result_t   pending_welds [$];
    stim_row_t      dir_rows [NUM_DIR];

    int fails = 0;
    int burst_left = 0;
    int rdy_mode = 0;
    int rdy_left = 0;
    int n_sets = 0;
    int n_tol_writes = 0;
    int n_hits = 0;
    int n_new = 0;
    int n_full = 0;
    int n_checked = 0;

    vertex_dedup_table_unit #(
        .MAX_VERTS(MAX_VERTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 clk = ~clk;

    // Search the welded set in storage order; append on a miss if room is left
    function automatic weld_result_t weld_vertex(int cx, int cy, int cz, bit last);
        weld_result_t r;
        int           c [3];
        longint       d;
        bit           hit;
        int unsigned  i;
        r = '0;
        hit = 1'b0;
        c[0] = cx;
        c[1] = cy;
        c[2] = cz;
        for (i = 0; i < weld_count && !hit; i++)
        begin
            hit = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                d = longint'(c[a]) - longint'(uniq_tbl[i][a]);
                if (d < 0)
                    d = -d;
                if (d > longint'(weld_tol))
                    hit = 1'b0;
            end
            if (hit)
                r.vertex_index = i[VIDX_W-1:0];
        end
        if (!hit)
        begin
            if (weld_count < MAX_VERTS)
            begin
                uniq_tbl[weld_count] = c;
                r.vertex_index = weld_count[VIDX_W-1:0];
                r.is_new = 1'b1;
                weld_count++;
            end
            else
            begin
                r.table_full = 1'b1;
            end
        end
        r.unique_count = weld_count[VCNT_W-1:0];
        if (last)
            weld_count = 0;
        return r;
    endfunction

    // Coordinate near a base: exact, small step, random within the tolerance, or right at / past it
    function automatic int near_coord(int base);
        longint d;
        case ($urandom_range(0, 4))
            0: d = 0;
            1: d = longint'($urandom_range(0, 6)) - 3;
            2: d = longint'(weld_tol);
            3: d = -(longint'(weld_tol) + 1);
            default:
            begin
                d = longint'($urandom_range(0, weld_tol));
                if ($urandom_range(0, 1))
                    d = -d;
            end
        endcase
        return int'(longint'(base) + d);
    endfunction

    // Present one vertex in bursts with random gaps; predict on transfer
    task automatic send_vertex(input int x, input int y, input int z, input bit last,
                               output weld_result_t pred);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        pred = weld_vertex(x, y, z, last);
        if (last)
            n_sets++;
    endtask

    // Hold the sender off until every pending result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_welds.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_tol(input bit [TOL_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        weld_tol = v;
        n_tol_writes++;
    endtask

    // Result side: check each transfer, then pick the next ready value
    always @(posedge clk)
    begin
        weld_result_t exp_r;
        weld_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[VCNT_W+VIDX_W+1:0];
            if (pending_welds.size() == 0)
            begin
                $error("result with no pending vertex: tdata %h", m_axis_tdata);
                fails++;
            end
            else
            begin
                exp_r = pending_welds.pop_front();
                n_checked++;
                if (got.vertex_index !== exp_r.vertex_index)
                begin
                    $error("vertex_index: expected %0d, actual %0d",
                           exp_r.vertex_index, got.vertex_index);
                    fails++;
                end
                if (got.is_new !== exp_r.is_new)
                begin
                    $error("is_new: expected %0d, actual %0d", exp_r.is_new, got.is_new);
                    fails++;
                end
                if (got.table_full !== exp_r.table_full)
                begin
                    $error("table_full: expected %0d, actual %0d",
                           exp_r.table_full, got.table_full);
                    fails++;
                end
                if (got.unique_count !== exp_r.unique_count)
                begin
                    $error("unique_count: expected %0d, actual %0d",
                           exp_r.unique_count, got.unique_count);
                    fails++;
                end
                if (exp_r.table_full)
                    n_full++;
                else if (exp_r.is_new)
                    n_new++;
                else
                    n_hits++;
            end
        end
        // ready pattern: always on, coin flip, or one cycle in four
        if (rdy_left == 0)
        begin
            rdy_mode = $urandom_range(0, 2);
            rdy_left = $urandom_range(5, 60);
        end
        rdy_left--;
        case (rdy_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= (rdy_left % 4 == 0);
        endcase
    end

    // Watchdog
    initial
    begin
        #200_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        weld_result_t pred;
        weld_result_t typed_r;
        int           pool [POOL_SZ][3];
        int           extremes [4];
        int           cx;
        int           cy;
        int           cz;
        int           set_len;
        int           sent;
        int           pick;
        int           b;
        bit [TOL_W-1:0] new_tol;

        extremes = '{C_MIN, C_MAX, 0, -1};

        // Directed rows; tolerance is 1 out of reset
        dir_rows = '{
            '{0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 1},               // first vertex
            '{0, 0, 1, -1, 1, 0, 1, 0, 0, 0, 1},              // within tolerance
            '{0, 0, 2, 0, 0, 0, 1, 1, 1, 0, 2},               // one past tolerance
            '{0, 0, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0, 0, 0},
            '{0, 0, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0},
            '{0, 0, C_MIN + 1, C_MIN, C_MIN + 1, 0, 0, 0, 0, 0, 0},
            '{0, 0, C_MAX, C_MIN, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 1, -1, 1, 0, 0, 0, 0, 0},              // last on a match
            '{0, 0, C_MAX, C_MAX, C_MAX, 0, 1, 0, 1, 0, 1},   // set cleared
            '{0, 0, 3, 3, 3, 1, 1, 1, 1, 0, 2},               // last on a new entry
            '{0, 0, 3, 3, 3, 1, 1, 0, 1, 0, 1},               // one-vertex set
            '{1, 0, 10, 20, 30, 0, 1, 0, 1, 0, 1},            // exact match only
            '{0, 0, 10, 20, 31, 0, 0, 0, 0, 0, 0},
            '{0, 0, 10, 20, 30, 0, 0, 0, 0, 0, 0},
            '{0, 0, -1, -1, -1, 0, 0, 0, 0, 0, 0},
            '{1, TOL_MAX, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0, 0, 0}, // widest tolerance
            '{0, 0, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0},
            '{0, 0, C_MIN, C_MAX, 0, 1, 0, 0, 0, 0, 0},
            '{0, 0, C_MIN, C_MIN, C_MIN, 0, 1, 0, 1, 0, 1},
            '{0, 0, C_MAX, C_MAX, C_MAX, 1, 0, 0, 0, 0, 0},   // full-range difference
            '{1, 1, 5, 5, 5, 1, 1, 0, 1, 0, 1}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        for (int r = 0; r < NUM_DIR; r++)
        begin
            if (dir_rows[r].set_tol)
            begin
                drain_results();
                write_tol(dir_rows[r].tol);
            end
            send_vertex(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z, dir_rows[r].last, pred);
            if (dir_rows[r].typed)
            begin
                typed_r.vertex_index = dir_rows[r].e_idx;
                typed_r.is_new       = dir_rows[r].e_new;
                typed_r.table_full   = dir_rows[r].e_full;
                typed_r.unique_count = dir_rows[r].e_cnt;
                pending_welds.push_back(typed_r);
            end
            else
            begin
                pending_welds.push_back(pred);
            end
        end

        // Fill one set to capacity, then overflow, match the top entry, overflow on last
        drain_results();
        write_tol('0);
        for (int i = 0; i < MAX_VERTS; i++)
        begin
            send_vertex(i * 65536 + i, -i, i ^ 32'h5A5A_0000, 1'b0, pred);
            pending_welds.push_back(pred);
        end
        send_vertex(C_MIN, 0, 0, 1'b0, pred);
        pending_welds.push_back(pred);
        send_vertex((MAX_VERTS - 1) * 65536 + (MAX_VERTS - 1), -(MAX_VERTS - 1),
                    (MAX_VERTS - 1) ^ 32'h5A5A_0000, 1'b0, pred);
        pending_welds.push_back(pred);
        send_vertex(C_MAX, C_MAX, C_MAX, 1'b1, pred);
        pending_welds.push_back(pred);
        send_vertex(0, 0, 0, 1'b1, pred);
        pending_welds.push_back(pred);

        // Random sets, one tolerance setting per phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0: new_tol = '0;
                1: new_tol = TOL_MAX;
                2: new_tol = $urandom_range(2, 300);
                3: new_tol = $urandom() & TOL_MAX;
                4: new_tol = 1;
                default: new_tol = $urandom_range(0, 40);
            endcase
            write_tol(new_tol);
            sent = 0;
            while (sent < PHASE_LEN)
            begin
                set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                      : $urandom_range(4, 40);
                for (int k = 0; k < POOL_SZ; k++)
                    for (int a = 0; a < 3; a++)
                        pool[k][a] = ($urandom_range(0, 9) == 0) ? extremes[$urandom_range(0, 3)]
                                                                 : int'($urandom());
                for (int j = 0; j < set_len; j++)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 14)
                    begin
                        b  = $urandom_range(0, POOL_SZ - 1);
                        cx = near_coord(pool[b][0]);
                        cy = near_coord(pool[b][1]);
                        cz = near_coord(pool[b][2]);
                    end
                    else if (pick < 17)
                    begin
                        cx = $urandom();
                        cy = $urandom();
                        cz = $urandom();
                    end
                    else
                    begin
                        cx = extremes[$urandom_range(0, 3)];
                        cy = extremes[$urandom_range(0, 3)];
                        cz = extremes[$urandom_range(0, 3)];
                    end
                    send_vertex(cx, cy, cz, j == set_len - 1, pred);
                    pending_welds.push_back(pred);
                    sent++;
                end
            end
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("Checked %0d results over %0d vertex sets with %0d tolerance settings.",
                 n_checked, n_sets, n_tol_writes);
        $display("Welded %0d, new %0d, table full %0d; one set filled to %0d entries.",
                 n_hits, n_new, n_full, MAX_VERTS);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
